>>> rtl/msm_pkg.sv
// ============================================================================
// msm_pkg
// Shared types and constants of the masked 3x3 depth smoother.
// ============================================================================
package msm_pkg;

  // Field widths
  localparam int DEPTH_BITS    = 24;
  localparam int CONF_BITS     = 8;
  localparam int CFG_BITS      = 12;
  localparam int CFG_IDX_BITS  = 2;

  // Frame geometry
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 2048;
  // Row counter runs up to height + 1 while the last outputs are flushed
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT + 2);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_BITS-1:0]  RST_WIDTH     = 12'd640;
  localparam logic [CFG_BITS-1:0]  RST_HEIGHT    = 12'd480;
  localparam logic [CONF_BITS-1:0] RST_THRESHOLD = 8'd128;

  // Item kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic signed [DEPTH_BITS-1:0] msm_depth_t;

  // 3x3 window: [row][column], row 0 oldest, column 2 newest
  typedef msm_depth_t [2:0][2:0] msm_win_t;

  typedef struct packed {
    logic                 action;
    msm_depth_t           depth_in;
    logic [CONF_BITS-1:0] confidence_in;
  } msm_in_t;

  typedef struct packed {
    msm_depth_t depth_out;
    logic       frame_end;
  } msm_out_t;

  // One line memory entry per column
  typedef struct packed {
    logic [CONF_BITS-1:0] conf;   // confidence of the previous row
    msm_depth_t           row1;   // depth of the previous row
    msm_depth_t           row2;   // depth two rows back
  } msm_line_t;

  // Control that travels with an item through the mean pipeline
  typedef struct packed {
    logic res;        // item gives a result
    logic smooth;     // interior and low confidence
    logic frame_end;  // last pixel of the frame
  } msm_tag_t;

endpackage

>>> rtl/msm_ram.sv
// ============================================================================
// msm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/msm_mean.sv
// ============================================================================
// msm_mean
// Mean of the positive depths in the 3x3 window: row sums, total with
// reciprocal lookup, split multiply, then select against the center depth.
// ============================================================================
module msm_mean (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  msm_pkg::msm_tag_t tag_i,
  input  msm_pkg::msm_depth_t centre_i,
  input  msm_pkg::msm_win_t win_i,
  output msm_pkg::msm_tag_t tag_o,
  output msm_pkg::msm_depth_t depth_o
);
  import msm_pkg::*;

  // Positive depths are below 2^(DEPTH_BITS-1); nine of them fit SUM_W bits
  localparam int MAG_W    = DEPTH_BITS - 1;
  localparam int ROW_W    = DEPTH_BITS + 1;
  localparam int SUM_W    = DEPTH_BITS + 3;
  // ceil(2^K / n) with K = SUM_W + 4 gives an exact floor for n up to 9
  localparam int RCP_K    = SUM_W + 4;
  localparam int RCP_W    = SUM_W + 5;
  localparam int RCP_LO_W = RCP_W / 2;
  localparam int RCP_HI_W = RCP_W - RCP_LO_W;
  localparam int PROD_W   = SUM_W + RCP_W;

  localparam logic [63:0] TWO_K = 64'd1 << RCP_K;
  localparam logic [RCP_W-1:0] RCP1 = RCP_W'(TWO_K);
  localparam logic [RCP_W-1:0] RCP2 = RCP_W'((TWO_K + 64'd1) / 64'd2);
  localparam logic [RCP_W-1:0] RCP3 = RCP_W'((TWO_K + 64'd2) / 64'd3);
  localparam logic [RCP_W-1:0] RCP4 = RCP_W'((TWO_K + 64'd3) / 64'd4);
  localparam logic [RCP_W-1:0] RCP5 = RCP_W'((TWO_K + 64'd4) / 64'd5);
  localparam logic [RCP_W-1:0] RCP6 = RCP_W'((TWO_K + 64'd5) / 64'd6);
  localparam logic [RCP_W-1:0] RCP7 = RCP_W'((TWO_K + 64'd6) / 64'd7);
  localparam logic [RCP_W-1:0] RCP8 = RCP_W'((TWO_K + 64'd7) / 64'd8);
  localparam logic [RCP_W-1:0] RCP9 = RCP_W'((TWO_K + 64'd8) / 64'd9);

  // Stage A: mask and row sums
  logic [2:0][2:0]       pos;
  logic [2:0][ROW_W-1:0] rsum;
  logic [2:0][ROW_W-1:0] a_rsum_q;
  logic [3:0]            a_cnt_q;
  msm_tag_t              a_tag_q;
  msm_depth_t            a_centre_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = '0;
      for (int j = 0; j < 3; j++) begin
        pos[i][j] = !win_i[i][j][DEPTH_BITS-1] && (|win_i[i][j]);
        if (pos[i][j]) begin
          rsum[i] = rsum[i] + ROW_W'(win_i[i][j][MAG_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
    end else if (adv_i) begin
      a_tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_rsum_q   <= rsum;
      a_cnt_q    <= 4'($countones(pos));
      a_centre_q <= centre_i;
    end
  end

  // Stage B: total and reciprocal of the count
  logic [SUM_W-1:0] total;
  logic [RCP_W-1:0] rcp;
  logic [SUM_W-1:0] b_total_q;
  logic [RCP_W-1:0] b_rcp_q;
  logic             b_nz_q;
  msm_tag_t         b_tag_q;
  msm_depth_t       b_centre_q;

  assign total = SUM_W'(a_rsum_q[0]) + SUM_W'(a_rsum_q[1]) + SUM_W'(a_rsum_q[2]);

  always_comb begin
    unique case (a_cnt_q)
      4'd1:    rcp = RCP1;
      4'd2:    rcp = RCP2;
      4'd3:    rcp = RCP3;
      4'd4:    rcp = RCP4;
      4'd5:    rcp = RCP5;
      4'd6:    rcp = RCP6;
      4'd7:    rcp = RCP7;
      4'd8:    rcp = RCP8;
      4'd9:    rcp = RCP9;
      default: rcp = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_tag_q <= '0;
    end else if (adv_i) begin
      b_tag_q <= a_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_total_q  <= total;
      b_rcp_q    <= rcp;
      b_nz_q     <= (a_cnt_q != 4'd0);
      b_centre_q <= a_centre_q;
    end
  end

  // Stage C: two partial products
  logic [SUM_W+RCP_LO_W-1:0] c_plo_q;
  logic [SUM_W+RCP_HI_W-1:0] c_phi_q;
  logic                      c_nz_q;
  msm_tag_t                  c_tag_q;
  msm_depth_t                c_centre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_tag_q <= '0;
    end else if (adv_i) begin
      c_tag_q <= b_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_plo_q    <= (SUM_W+RCP_LO_W)'(b_total_q) *
                    (SUM_W+RCP_LO_W)'(b_rcp_q[RCP_LO_W-1:0]);
      c_phi_q    <= (SUM_W+RCP_HI_W)'(b_total_q) *
                    (SUM_W+RCP_HI_W)'(b_rcp_q[RCP_W-1:RCP_LO_W]);
      c_nz_q     <= b_nz_q;
      c_centre_q <= b_centre_q;
    end
  end

  // Stage D: combine, take the quotient, pick mean or center
  logic [PROD_W-1:0]     prod;
  logic [DEPTH_BITS-1:0] quot;

  assign prod = (PROD_W'(c_phi_q) << RCP_LO_W) + PROD_W'(c_plo_q);
  assign quot = prod[RCP_K +: DEPTH_BITS];

  assign tag_o   = c_tag_q;
  assign depth_o = (c_tag_q.smooth && c_nz_q) ? msm_depth_t'(quot) : c_centre_q;

endmodule

>>> rtl/masked_3x3_depth_smoother_top.sv
// ============================================================================
// masked_3x3_depth_smoother_top
// Streaming 3x3 depth smoother: low-confidence interior pixels are replaced
// by the truncated mean of the positive depths in their window.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    in_data_i  (msm_in_t)
//   out      output     out_valid_o / out_ready_i  out_data_o (msm_out_t)
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One item per cycle when not stalled. A pixel's result is loaded into the
// output register once the item that completes its window (one row and one
// pixel later) has passed the line memory read, the window stage and the three
// register stages of the mean pipeline.
// The line memory starts undefined, no clearing pass.
// The whole pipeline stalls only while its last stage holds a result and
// the output register is full and not taken.
// ============================================================================
module masked_3x3_depth_smoother_top #(
  parameter int MAX_WIDTH = msm_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  msm_pkg::msm_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output msm_pkg::msm_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [msm_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [msm_pkg::CFG_BITS-1:0]      cfg_data_i
);
  import msm_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = ((COL_W > CFG_BITS) ? COL_W : CFG_BITS) + 2;
  localparam int LINE_W = $bits(msm_line_t);

  // Configuration registers
  logic [CFG_BITS-1:0]  width_q, height_q;
  logic [CONF_BITS-1:0] thr_q;
  logic                 cfg_restart;

  assign cfg_restart = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      thr_q    <= RST_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:     width_q  <= cfg_data_i;
        REG_HEIGHT:    height_q <= cfg_data_i;
        REG_THRESHOLD: thr_q    <= cfg_data_i[CONF_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // Clamped frame size
  logic [CMP_W-1:0] eff_w, eff_h, w_ext, h_ext;

  assign w_ext = CMP_W'(width_q);
  assign h_ext = CMP_W'(height_q);

  always_comb begin
    if (w_ext < CMP_W'(3)) begin
      eff_w = CMP_W'(3);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (h_ext < CMP_W'(3)) begin
      eff_h = CMP_W'(3);
    end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
      eff_h = CMP_W'(MAX_HEIGHT);
    end else begin
      eff_h = h_ext;
    end
  end

  // Stall control
  logic     adv;
  msm_tag_t res_tag;
  logic     out_valid_q;

  assign adv        = !(res_tag.res && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;

  // Input position and per-item decisions
  logic [COL_W-1:0]    col_q;
  logic [ROW_BITS-1:0] row_q;
  logic [CMP_W-1:0]    col_x, row_x;
  logic                acc, draining, take;
  logic                emit, inter, fend;
  msm_depth_t          d_in;
  logic [CONF_BITS-1:0] cf_in;

  assign col_x    = CMP_W'(col_q);
  assign row_x    = CMP_W'(row_q);
  assign acc      = in_valid_i && adv;
  assign draining = row_x >= eff_h;
  // Drain items are dropped mid-frame; pixels act as drains while flushing
  assign take     = acc && (draining || in_data_i.action == ACT_PIXEL);
  assign d_in     = draining ? '0 : in_data_i.depth_in;
  assign cf_in    = draining ? '0 : in_data_i.confidence_in;

  assign emit  = (row_x >= CMP_W'(2)) || (row_x == CMP_W'(1) && col_x != '0);
  assign inter = (col_x >= CMP_W'(2)) && (row_x >= CMP_W'(2)) &&
                 (row_x <= eff_h - CMP_W'(1));
  // Last output of the frame is emitted at column 0 of row height + 1
  assign fend  = emit && (col_x == '0) && (row_x == eff_h + CMP_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (fend) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_x == eff_w - CMP_W'(1)) begin
        col_q <= '0;
        row_q <= row_q + ROW_BITS'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // Stage 1 registers: item waits for the line memory read
  logic                 s1_valid_q, s1_emit_q, s1_inter_q, s1_fend_q;
  msm_depth_t           s1_depth_q;
  logic [CONF_BITS-1:0] s1_conf_q;
  logic [COL_W-1:0]     s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_emit_q  <= emit;
      s1_inter_q <= inter;
      s1_fend_q  <= fend;
      s1_depth_q <= d_in;
      s1_conf_q  <= cf_in;
      s1_addr_q  <= col_q;
    end
  end

  // Line memory: read at accept, written back from the stage 1 registers
  msm_line_t rd_line, wr_line;
  logic      line_we;

  assign line_we      = adv && s1_valid_q;
  assign wr_line.conf = s1_conf_q;
  assign wr_line.row1 = s1_depth_q;
  assign wr_line.row2 = rd_line.row1;

  msm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_line),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (rd_line)
  );

  // Window shift and confidence delay
  msm_win_t             win_q;
  logic [CONF_BITS-1:0] conf_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      conf_hold_q <= '0;
    end else if (line_we) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_line.row2;
      win_q[1][2] <= rd_line.row1;
      win_q[2][2] <= s1_depth_q;
      conf_hold_q <= rd_line.conf;
    end
  end

  // Stage 2 registers: center and decision of the pixel leaving the window
  msm_tag_t   s2_tag_q, s2_tag_d;
  msm_depth_t s2_centre_q;

  assign s2_tag_d.res       = s1_valid_q && s1_emit_q;
  assign s2_tag_d.smooth    = s1_inter_q && (conf_hold_q < thr_q);
  assign s2_tag_d.frame_end = s1_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q <= '0;
    end else if (adv) begin
      s2_tag_q <= s2_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_centre_q <= win_q[1][2];
    end
  end

  // Mean pipeline
  msm_depth_t res_depth;

  msm_mean u_mean (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .tag_i    (s2_tag_q),
    .centre_i (s2_centre_q),
    .win_i    (win_q),
    .tag_o    (res_tag),
    .depth_o  (res_depth)
  );

  // Output register
  msm_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_tag.res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_tag.res) begin
      out_data_q.depth_out <= res_depth;
      out_data_q.frame_end <= res_tag.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_stall_holds_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(win_q))
    else $error("window moved during a stall");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_x <= eff_h + CMP_W'(1))
    else $error("row counter ran past the flush row");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_x < eff_w)
    else $error("column counter ran past the row width");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output");

endmodule

>>> tb/sv/tb_masked_3x3_depth_smoother_top.sv
// ============================================================================
// tb_masked_3x3_depth_smoother_top
// Self-checking bench for the masked 3x3 depth smoother. Pixel frames go in
// through the valid/ready input. A behavioral smoother inside the bench works
// out every output pixel, and a checker compares each output item in order.
// The bench covers the extreme depths and confidences, size clamping,
// threshold masking, frame restarts, drain handling, random frames, random
// gaps on both sides and a long output stall.
// ============================================================================
module tb_masked_3x3_depth_smoother_top;
  import msm_pkg::*;

  localparam int          MAX_COLS     = DEF_MAX_WIDTH;
  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 8;
  localparam int          SETTLE_CYC   = 16;    // output latency plus margin
  localparam int          END_CYCLES   = 24;
  localparam int          HOLD_CYCLES  = 300;   // long output stall
  localparam int          STALL_LIMIT  = 3000;  // cycles without any transfer
  localparam int          RANDOM_ITEMS = 350;
  localparam int unsigned ALL          = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;  // not decoded

  localparam msm_depth_t DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam msm_depth_t DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  // DUT signals
  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  msm_in_t                 in_data;
  logic                    out_valid;
  logic                    out_ready;
  msm_out_t                out_data;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CFG_BITS-1:0]     cfg_data;

  // Bench control
  bit          gaps_on;
  bit          hold_off_req;
  int unsigned err_cnt;
  int unsigned useful_items;
  int unsigned stall_cycles;

  // Behavioral smoother state
  msm_depth_t           sm_line_a [MAX_COLS];
  msm_depth_t           sm_line_b [MAX_COLS];
  logic [CONF_BITS-1:0] sm_conf_line [MAX_COLS];
  msm_depth_t           sm_win [3][3];
  logic [CONF_BITS-1:0] sm_conf_hold;
  int unsigned          sm_col;
  int unsigned          sm_row;
  int unsigned          sm_out_cnt;
  logic [CFG_BITS-1:0]  sm_width;
  logic [CFG_BITS-1:0]  sm_height;
  logic [CONF_BITS-1:0] sm_thresh;

  // Output pixels still due from the block, oldest first
  msm_out_t due_pixels [$];

  masked_3x3_depth_smoother_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral smoother
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_cols();
    if (sm_width < 3) return 3;
    if (sm_width > MAX_COLS) return MAX_COLS;
    return 32'(sm_width);
  endfunction

  function automatic int unsigned eff_rows();
    if (sm_height < 3) return 3;
    if (sm_height > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(sm_height);
  endfunction

  function automatic void smoother_restart();
    sm_col     = 0;
    sm_row     = 0;
    sm_out_cnt = 0;
  endfunction

  function automatic void smoother_reset();
    for (int k = 0; k < MAX_COLS; k++) begin
      sm_line_a[k]    = '0;
      sm_line_b[k]    = '0;
      sm_conf_line[k] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        sm_win[i][j] = '0;
    sm_conf_hold = '0;
    smoother_restart();
    sm_width  = RST_WIDTH;
    sm_height = RST_HEIGHT;
    sm_thresh = RST_THRESHOLD;
  endfunction

  function automatic void smoother_set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_BITS-1:0]     val);
    case (idx)
      REG_WIDTH: begin
        sm_width = val;
        smoother_restart();
      end
      REG_HEIGHT: begin
        sm_height = val;
        smoother_restart();
      end
      REG_THRESHOLD: sm_thresh = val[CONF_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advance by one accepted item; queue the output pixel it releases, if any
  function automatic void smoother_step(input msm_in_t it);
    int unsigned          w, h, c, ro, co;
    bit                   draining, emits;
    msm_depth_t           d, centre;
    logic [CONF_BITS-1:0] cf, centre_conf;
    longint               sum, cnt;
    msm_out_t             res;
    w        = eff_cols();
    h        = eff_rows();
    draining = (sm_row >= h);
    // drain items are ignored while the frame still expects pixels
    if (!draining && it.action == ACT_DRAIN) return;
    d  = '0;
    cf = '0;
    if (!draining) begin
      d  = it.depth_in;
      cf = it.confidence_in;
    end
    c           = sm_col;
    centre      = sm_win[1][2];
    centre_conf = sm_conf_hold;
    sm_conf_hold    = sm_conf_line[c];
    sm_conf_line[c] = cf;
    for (int i = 0; i < 3; i++) begin
      sm_win[i][0] = sm_win[i][1];
      sm_win[i][1] = sm_win[i][2];
    end
    sm_win[0][2] = sm_line_b[c];
    sm_win[1][2] = sm_line_a[c];
    sm_win[2][2] = d;
    sm_line_b[c] = sm_line_a[c];
    sm_line_a[c] = d;

    // output position lags one row and one pixel
    emits = (sm_row >= 2) || (sm_row == 1 && sm_col >= 1);
    ro = 0;
    co = 0;
    if (emits) begin
      if (sm_col >= 1) begin
        ro = sm_row - 1;
        co = sm_col - 1;
      end else begin
        ro = sm_row - 2;
        co = w - 1;
      end
    end
    sm_col++;
    if (sm_col >= w) begin
      sm_col = 0;
      sm_row++;
    end
    if (!emits) return;

    // interior, low confidence: mean of the positive depths in the window
    if (ro >= 1 && ro + 2 <= h && co >= 1 && co + 2 <= w && centre_conf < sm_thresh) begin
      sum = 0;
      cnt = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (sm_win[i][j] > 0) begin
            sum += sm_win[i][j];
            cnt++;
          end
      if (cnt > 0) centre = msm_depth_t'(sum / cnt);
    end

    res.depth_out = centre;
    if (sm_out_cnt >= w * h - 1) begin
      res.frame_end = 1'b1;
      smoother_restart();
    end else begin
      res.frame_end = 1'b0;
      sm_out_cnt++;
    end
    due_pixels.insert(due_pixels.size(), res);
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  function automatic msm_depth_t rand_depth();
    msm_depth_t d;
    d = msm_depth_t'($urandom);
    case ($urandom_range(9))
      0: d = DEPTH_MAX;
      1: d = DEPTH_MIN;
      2: d = '0;
      3, 4: d[DEPTH_BITS-1] = 1'b1;
      5: d = msm_depth_t'($urandom_range(1, 1000));
      default: d[DEPTH_BITS-1] = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [CONF_BITS-1:0] rand_conf();
    logic [CONF_BITS-1:0] cf;
    cf = CONF_BITS'($urandom_range(255));
    case ($urandom_range(9))
      0: cf = '0;
      1: cf = '1;
      default: ;
    endcase
    return cf;
  endfunction

  function automatic msm_in_t rand_pixel();
    msm_in_t it;
    it.action        = ACT_PIXEL;
    it.depth_in      = rand_depth();
    it.confidence_in = rand_conf();
    return it;
  endfunction

  // drain payload is dropped by the block; keep it random anyway
  function automatic msm_in_t drain_item();
    msm_in_t it;
    it.action        = ACT_DRAIN;
    it.depth_in      = rand_depth();
    it.confidence_in = rand_conf();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item, with random gaps in front, and wait until it is taken
  task automatic send_item(input msm_in_t it);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    smoother_step(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0]     val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    smoother_set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, collect every due pixel and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // One frame at the current size with random content. keep_pix and keep_tail
  // cut it short; noise_pct sets the rate of drain items inside the frame.
  task automatic run_frame(input int unsigned keep_pix, input int unsigned keep_tail,
                           input int unsigned noise_pct);
    int unsigned npix, ncols, n;
    npix  = eff_cols() * eff_rows();
    ncols = eff_cols();
    for (n = 0; n < npix && n < keep_pix; n++) begin
      if ($urandom_range(99) < noise_pct) send_item(drain_item());
      send_item(rand_pixel());
      useful_items++;
    end
    if (keep_pix < npix) return;
    // flush: pixel items act as drains here
    for (n = 0; n <= ncols && n < keep_tail; n++) begin
      send_item($urandom_range(1) ? drain_item() : rand_pixel());
      useful_items++;
    end
  endtask

  // Output side: random gaps, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      out_ready <= !(gaps_on && $urandom_range(99) < 18);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    msm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected output item depth_out %0d frame_end %0b",
                 $time, out_data.depth_out, out_data.frame_end);
        err_cnt++;
      end else begin
        want = due_pixels.pop_front();
        if (out_data.depth_out !== want.depth_out) begin
          $display("%0t: depth_out expected %0d got %0d",
                   $time, want.depth_out, out_data.depth_out);
          err_cnt++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b got %0b",
                   $time, want.frame_end, out_data.frame_end);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_masked_3x3_depth_smoother_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, ignored drains, depth/confidence extremes, threshold edge
  task automatic test_directed_extremes();
    msm_depth_t           col_depth [7];
    logic [CONF_BITS-1:0] mid_conf [7];
    msm_in_t              it;
    // at the reset size nothing is released this early
    send_item(drain_item());
    send_item(rand_pixel());
    send_item(drain_item());
    send_item(rand_pixel());
    settle();
    write_reg(REG_WIDTH, 12'd7);
    write_reg(REG_HEIGHT, 12'd3);
    // window at column 1 all max depth, column 5 window has no positive depth
    col_depth = '{DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 24'sd1, DEPTH_MIN, '0, -24'sd1};
    // reset threshold 128: 127 smooths, 128 passes
    mid_conf  = '{8'd255, 8'd0, 8'd255, 8'd128, 8'd1, 8'd127, 8'd0};
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 7; c++) begin
        it.action        = ACT_PIXEL;
        it.depth_in      = col_depth[c];
        it.confidence_in = (r == 1) ? mid_conf[c] : rand_conf();
        if (r == 1 && c == 3) send_item(drain_item());
        send_item(it);
      end
    for (int c = 0; c < 8; c++) send_item(c == 4 ? rand_pixel() : drain_item());
    settle();
  endtask

  // Sizes below and above range are clamped; the wide and tall sizes only
  // run a partial frame
  task automatic test_size_clamping();
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd1);
    run_frame(ALL, ALL, 5);
    settle();
    write_reg(REG_WIDTH, 12'd2);
    write_reg(REG_HEIGHT, 12'd2);
    run_frame(ALL, ALL, 5);
    settle();
    write_reg(REG_WIDTH, 12'hFFF);
    write_reg(REG_HEIGHT, 12'd0);
    run_frame(40, 0, 1);
    settle();
    write_reg(REG_WIDTH, 12'd1);
    write_reg(REG_HEIGHT, 12'd2048);
    run_frame(30, 0, 1);
    settle();
  endtask

  // Threshold keeps only its low bits; the spare index changes nothing
  task automatic test_threshold_masking();
    write_reg(REG_WIDTH, 12'd5);
    write_reg(REG_HEIGHT, 12'd4);
    write_reg(REG_THRESHOLD, 12'hF00);
    run_frame(ALL, ALL, 5);
    settle();
    write_reg(REG_THRESHOLD, 12'hAFF);
    run_frame(ALL, ALL, 5);
    settle();
    write_reg(REG_SPARE, 12'h0AB);
    write_reg(REG_SPARE, 12'hF00);
    run_frame(ALL, ALL, 5);
    settle();
    write_reg(REG_THRESHOLD, 12'd128);
  endtask

  // A size write restarts the frame, mid-frame and while flushing
  task automatic test_restart_mid_frame();
    write_reg(REG_WIDTH, 12'd6);
    write_reg(REG_HEIGHT, 12'd5);
    run_frame(20, 0, 10);
    settle();
    write_reg(REG_HEIGHT, 12'd4);
    run_frame(ALL, 3, 5);
    settle();
    write_reg(REG_WIDTH, 12'd6);
    run_frame(ALL, ALL, 5);
    settle();
  endtask

  // Output held off long enough that the block must stall its input
  task automatic test_output_stall();
    write_reg(REG_WIDTH, 12'd8);
    write_reg(REG_HEIGHT, 12'd8);
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    run_frame(ALL, ALL, 0);
    settle();
    gaps_on = 1'b1;
  endtask

  // Random sizes, thresholds and content; some frames are cut short
  task automatic test_random_frames();
    int unsigned frame_no;
    frame_no     = 0;
    useful_items = 0;
    gaps_on      = 1'b0;
    while (useful_items < RANDOM_ITEMS) begin
      if (frame_no == 3) gaps_on = 1'b1;
      write_reg(REG_WIDTH, 12'($urandom_range(3, 16)));
      write_reg(REG_HEIGHT, 12'($urandom_range(3, 10)));
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: write_reg(REG_THRESHOLD, 12'd0);
          1: write_reg(REG_THRESHOLD, 12'd255);
          default: write_reg(REG_THRESHOLD, 12'($urandom_range(4095)));
        endcase
      end
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1))
          run_frame($urandom_range(eff_cols() * eff_rows() - 1), 0, 5);
        else
          run_frame(ALL, $urandom_range(eff_cols()), 5);
      end else begin
        run_frame(ALL, ALL, 5);
      end
      settle();
      frame_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    err_cnt      = 0;
    useful_items = 0;
    stall_cycles = 0;
    smoother_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_size_clamping();
    test_threshold_masking();
    test_restart_mid_frame();
    test_output_stall();
    test_random_frames();

    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("tb_masked_3x3_depth_smoother_top: clean");
    else $display("tb_masked_3x3_depth_smoother_top: errors");
    $finish;
  end

endmodule
